/* rtl/dual_cpu_mailbox_fifo_assert.svh */
// Assertion macros shared by the mailbox RTL.
// Included inside module bodies that declare clk_i and rst_ni.
`ifndef DUAL_CPU_MAILBOX_FIFO_ASSERT_SVH
`define DUAL_CPU_MAILBOX_FIFO_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define DCMBX_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mailbox assertion failed");

// Check a condition in the cycle after its trigger.
`define DCMBX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mailbox assertion failed");

`endif

/* rtl/dcmbx_pkg.sv */
// Package for the dual-CPU mailbox: register codes, status codes,
// control word constants and the FIFO control structs. No dependencies.
`timescale 1ns / 1ps

package dcmbx_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 6;

  // Register select codes
  typedef enum logic [2:0] {
    REG_MSCOM = 3'd0,
    REG_SMCOM = 3'd1,
    REG_MSFLG = 3'd2,
    REG_SMFLG = 3'd3,
    REG_CTRL  = 3'd4,
    REG_BD6   = 3'd5,
    REG_FIFO0 = 3'd6,
    REG_FIFO1 = 3'd7
  } reg_sel_e;

  // Access kind and requesting side
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;
  localparam logic SIDE_MAIN  = 1'b0;
  localparam logic SIDE_SUB   = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY_POP = 2'd1,
    ST_FULL_DROP = 2'd2
  } status_e;

  // Control word fields
  localparam logic [DATA_W-1:0] CTRL_MAIN_MASK   = 32'h0000_0100;
  localparam logic [DATA_W-1:0] CTRL_TOGGLE_MASK = 32'h0000_00F0;
  localparam logic [DATA_W-1:0] CTRL_FORCE_TRIG  = 32'h0000_00A0;
  localparam logic [DATA_W-1:0] CTRL_FIELD_MASK  = 32'h0000_F000;
  localparam logic [DATA_W-1:0] CTRL_FIELD_VAL   = 32'h0000_2000;

  // FIFO request and flags between the top level and each FIFO
  typedef struct packed {
    logic push;
    logic pop;
  } fifo_req_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_flags_t;

endpackage

/* rtl/dcmbx_fifo.sv */
// Word FIFO for the mailbox: circular buffer in an array memory with
// head/tail pointers and a fill count. Depends on dcmbx_pkg.
`timescale 1ns / 1ps

module dcmbx_fifo #(
  parameter int unsigned Depth = 32,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dcmbx_pkg::fifo_req_t            req_i,
  input  logic [dcmbx_pkg::DATA_W-1:0]    wdata_i,
  output logic [dcmbx_pkg::DATA_W-1:0]    rdata_o,
  output logic [CntW-1:0]                 fill_o,
  output dcmbx_pkg::fifo_flags_t          flags_o
);
  import dcmbx_pkg::*;
  `include "dual_cpu_mailbox_fifo_assert.svh"

  localparam int unsigned AddrW = $clog2(Depth);

  logic [DATA_W-1:0] mem_q [Depth];
  logic [DATA_W-1:0] rdata_q;
  logic [AddrW-1:0]  head_q, head_d;
  logic [AddrW-1:0]  tail_q, tail_d;
  logic [CntW-1:0]   fill_q, fill_d;

  // Advance pointers with wrap at the depth
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (req_i.pop) begin
      head_d = (head_q == AddrW'(Depth - 1)) ? '0 : head_q + 1'b1;
    end
    if (req_i.push) begin
      tail_d = (tail_q == AddrW'(Depth - 1)) ? '0 : tail_q + 1'b1;
    end
  end

  // Update fill count
  always_comb begin
    case ({req_i.push, req_i.pop})
      2'b10:   fill_d = fill_q + 1'b1;
      2'b01:   fill_d = fill_q - 1'b1;
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
    end
  end

  // Write at tail, read head into the data register on pop
  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      mem_q[tail_q] <= wdata_i;
    end
    if (req_i.pop) begin
      rdata_q <= mem_q[head_q];
    end
  end

  assign rdata_o       = rdata_q;
  assign fill_o        = fill_q;
  assign flags_o.empty = (fill_q == '0);
  assign flags_o.full  = (fill_q == CntW'(Depth));

  `DCMBX_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= CntW'(Depth))
  `DCMBX_ASSERT_NOW(a_no_bad_req, req_i.push || req_i.pop,
                    !(req_i.push && flags_o.full) && !(req_i.pop && flags_o.empty))
  `DCMBX_ASSERT_NEXT(a_pop_dec, req_i.pop && !req_i.push,
                     fill_q == CntW'($past(fill_q) - 1'b1))

endmodule

/* rtl/dual_cpu_mailbox_fifo.sv */
// Dual-processor mailbox with command, flag, control and boot words and
// two word FIFOs. Depends on dcmbx_pkg and dcmbx_fifo.
`timescale 1ns / 1ps

// One register access per transaction, one result per access. An access
// is taken into an input register, then in a single pass decoded,
// applied to its word or FIFO pointer and captured in the result
// register, so the block sustains one access per clock cycle while the
// output is not back-pressured. The fifo1 pop data comes from the
// registered read port of its memory, loaded in that same pass.
// While a result waits on the output, one more access is held in the
// input register; the input side stalls only when both are occupied.
// FIFO counts on the result are the fill levels after the access, taken
// modulo 64.
module dual_cpu_mailbox_fifo #(
  parameter int unsigned FIFO_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] write_data
  input  logic [4:0]  s_axis_tuser,   // [0] mode, [1] side, [4:2] reg_sel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [31:0] read_data, [37:32] fifo0_count,
                                      // [43:38] fifo1_count, [47:44] zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);
  import dcmbx_pkg::*;
  `include "dual_cpu_mailbox_fifo_assert.svh"

  localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);

  // Input register
  logic              a_valid_q, a_valid_d;
  logic              a_mode_q;
  logic              a_side_q;
  reg_sel_e          a_sel_q;
  logic [DATA_W-1:0] a_data_q;

  // Mailbox words
  logic [DATA_W-1:0] mscom_q, mscom_d;
  logic [DATA_W-1:0] smcom_q, smcom_d;
  logic [DATA_W-1:0] msflg_q, msflg_d;
  logic [DATA_W-1:0] smflg_q, smflg_d;
  logic [DATA_W-1:0] ctrl_q, ctrl_d;
  logic [DATA_W-1:0] boot_q, boot_d;

  // Result register
  logic               m_valid_q, m_valid_d;
  logic [DATA_W-1:0]  out_rd_q, rd_d;
  logic               out_pop_q, pop_d;
  logic [COUNT_W-1:0] out_c0_q, out_c1_q;
  status_e            out_status_q, status_d;

  // FIFO side
  fifo_req_t         f0_req, f1_req, f0_req_g, f1_req_g;
  fifo_flags_t       f0_flags, f1_flags;
  logic [CntW-1:0]   f0_fill, f1_fill;
  logic [CntW-1:0]   f0_after, f1_after;
  logic [DATA_W-1:0] f0_rdata, f1_rdata;

  logic in_acc;
  logic b_free;
  logic advance;

  // Handshake: the input register drains into the result register
  assign b_free        = !m_valid_q || m_axis_tready;
  assign advance       = a_valid_q && b_free;
  assign s_axis_tready = !a_valid_q || b_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign a_valid_d = in_acc ? 1'b1 : (advance ? 1'b0 : a_valid_q);
  assign m_valid_d = advance ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Capture the access
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_mode_q <= s_axis_tuser[0];
      a_side_q <= s_axis_tuser[1];
      a_sel_q  <= reg_sel_e'(s_axis_tuser[4:2]);
      a_data_q <= s_axis_tdata;
    end
  end

  // Decode the access and apply the side rules
  always_comb begin
    logic [DATA_W-1:0] ctrl_tmp;
    logic [DATA_W-1:0] tog;
    mscom_d  = mscom_q;
    smcom_d  = smcom_q;
    msflg_d  = msflg_q;
    smflg_d  = smflg_q;
    ctrl_d   = ctrl_q;
    boot_d   = boot_q;
    rd_d     = '0;
    pop_d    = 1'b0;
    status_d = ST_OK;
    f0_req   = '0;
    f1_req   = '0;
    ctrl_tmp = ctrl_q;
    tog      = a_data_q & CTRL_TOGGLE_MASK;
    if (a_mode_q == MODE_READ) begin
      unique case (a_sel_q)
        REG_MSCOM: rd_d = mscom_q;
        REG_SMCOM: rd_d = smcom_q;
        REG_MSFLG: rd_d = msflg_q;
        REG_SMFLG: rd_d = smflg_q;
        REG_CTRL:  rd_d = ctrl_q;
        REG_BD6, REG_FIFO0: rd_d = '0;
        REG_FIFO1: begin
          if (f1_flags.empty) begin
            status_d = ST_EMPTY_POP;
          end else begin
            f1_req.pop = 1'b1;
            pop_d      = 1'b1;
          end
        end
      endcase
    end else begin
      unique case (a_sel_q)
        REG_MSCOM: if (a_side_q == SIDE_MAIN) mscom_d = a_data_q;
        REG_SMCOM: if (a_side_q == SIDE_SUB)  smcom_d = a_data_q;
        REG_MSFLG: begin
          if (a_side_q == SIDE_MAIN) msflg_d = msflg_q | a_data_q;
          else                       msflg_d = msflg_q & ~a_data_q;
        end
        REG_SMFLG: begin
          if (a_side_q == SIDE_MAIN) smflg_d = smflg_q & ~a_data_q;
          else                       smflg_d = a_data_q;
        end
        REG_CTRL: begin
          if (a_side_q == SIDE_MAIN) begin
            ctrl_d = (ctrl_q & ~CTRL_MAIN_MASK) | (a_data_q & CTRL_MAIN_MASK);
          end else begin
            // Force the upper field, then toggle the mask group
            if ((a_data_q & CTRL_FORCE_TRIG) != '0) begin
              ctrl_tmp = (ctrl_q & ~CTRL_FIELD_MASK) | CTRL_FIELD_VAL;
            end
            ctrl_d = ((ctrl_tmp & tog) != '0) ? (ctrl_tmp & ~tog) : (ctrl_tmp | tog);
          end
        end
        REG_BD6: if (a_side_q == SIDE_MAIN) boot_d = a_data_q;
        REG_FIFO0: begin
          if (f0_flags.full) status_d = ST_FULL_DROP;
          else               f0_req.push = 1'b1;
        end
        REG_FIFO1: begin
          if (f1_flags.full) status_d = ST_FULL_DROP;
          else               f1_req.push = 1'b1;
        end
      endcase
    end
  end

  // Gate FIFO requests with the pass
  assign f0_req_g = advance ? f0_req : '0;
  assign f1_req_g = advance ? f1_req : '0;

  // Fill levels after this access
  assign f0_after = f0_req.push ? f0_fill + 1'b1 : f0_fill;
  assign f1_after = f1_req.push ? f1_fill + 1'b1 :
                    (f1_req.pop ? f1_fill - 1'b1 : f1_fill);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mscom_q <= '0;
      smcom_q <= '0;
      msflg_q <= '0;
      smflg_q <= '0;
      ctrl_q  <= '0;
      boot_q  <= '0;
    end else if (advance) begin
      mscom_q <= mscom_d;
      smcom_q <= smcom_d;
      msflg_q <= msflg_d;
      smflg_q <= smflg_d;
      ctrl_q  <= ctrl_d;
      boot_q  <= boot_d;
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_rd_q     <= rd_d;
      out_pop_q    <= pop_d;
      out_c0_q     <= COUNT_W'(f0_after);
      out_c1_q     <= COUNT_W'(f1_after);
      out_status_q <= status_d;
    end
  end

  dcmbx_fifo #(
    .Depth (FIFO_DEPTH)
  ) u_fifo0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (f0_req_g),
    .wdata_i (a_data_q),
    .rdata_o (f0_rdata),
    .fill_o  (f0_fill),
    .flags_o (f0_flags)
  );

  dcmbx_fifo #(
    .Depth (FIFO_DEPTH)
  ) u_fifo1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (f1_req_g),
    .wdata_i (a_data_q),
    .rdata_o (f1_rdata),
    .fill_o  (f1_fill),
    .flags_o (f1_flags)
  );

  // Drive the result channel
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0, out_c1_q, out_c0_q, (out_pop_q ? f1_rdata : out_rd_q)};
  assign m_axis_tuser  = out_status_q;

  `DCMBX_ASSERT_NOW(a_stall_holds_item, !s_axis_tready, a_valid_q && m_valid_q)
  `DCMBX_ASSERT_NOW(a_empty_pop_result, m_valid_q && (out_status_q == ST_EMPTY_POP),
                    !out_pop_q && (out_rd_q == '0) && (out_c1_q == '0))
  `DCMBX_ASSERT_NEXT(a_ctrl_force,
                     advance && (a_mode_q == MODE_WRITE) && (a_side_q == SIDE_SUB) &&
                     (a_sel_q == REG_CTRL) && ((a_data_q & CTRL_FORCE_TRIG) != '0),
                     ctrl_q[15:12] == 4'h2)

endmodule

/* dv/dual_cpu_mailbox_fifo_test.sv */
// Self-checking testbench for dual_cpu_mailbox_fifo: predicts every access
// in its own mailbox model and compares each result transaction field by field.
// Depends on dcmbx_pkg and the mailbox RTL.
`timescale 1ns / 1ps

module dual_cpu_mailbox_fifo_test;
  import dcmbx_pkg::*;

  localparam int unsigned FIFO_DEPTH = 32;
  localparam int unsigned MAX_REPORTS = 50;

  typedef struct packed {
    logic [31:0] read_data;
    logic [5:0]  fifo0_count;
    logic [5:0]  fifo1_count;
    status_e     status;
  } mbx_response_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [4:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  // Mailbox words as the predictor sees them; the boot word is write-only
  logic [31:0] main_cmd;
  logic [31:0] sub_cmd;
  logic [31:0] main_flags;
  logic [31:0] sub_flags;
  logic [31:0] ctrl_word;
  logic [31:0] fifo0_words[$];
  logic [31:0] fifo1_words[$];

  mbx_response_t pending_responses[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;

  dual_cpu_mailbox_fifo #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Apply one access to the mailbox model and return its result
  function automatic mbx_response_t mailbox_access(input logic mode, input logic side,
                                                   input reg_sel_e sel,
                                                   input logic [31:0] data);
    mbx_response_t rsp;
    logic [31:0]   toggle;
    rsp = '{read_data: '0, fifo0_count: '0, fifo1_count: '0, status: ST_OK};
    if (mode == MODE_READ) begin
      case (sel)
        REG_MSCOM: rsp.read_data = main_cmd;
        REG_SMCOM: rsp.read_data = sub_cmd;
        REG_MSFLG: rsp.read_data = main_flags;
        REG_SMFLG: rsp.read_data = sub_flags;
        REG_CTRL:  rsp.read_data = ctrl_word;
        REG_FIFO1: begin
          if (fifo1_words.size() == 0) rsp.status = ST_EMPTY_POP;
          else rsp.read_data = fifo1_words.pop_front();
        end
        default: ;
      endcase
    end else begin
      case (sel)
        REG_MSCOM: if (side == SIDE_MAIN) main_cmd = data;
        REG_SMCOM: if (side == SIDE_SUB) sub_cmd = data;
        REG_MSFLG: begin
          if (side == SIDE_MAIN) main_flags = main_flags | data;
          else main_flags = main_flags & ~data;
        end
        REG_SMFLG: begin
          if (side == SIDE_MAIN) sub_flags = sub_flags & ~data;
          else sub_flags = data;
        end
        REG_CTRL: begin
          if (side == SIDE_MAIN) begin
            ctrl_word = (ctrl_word & ~CTRL_MAIN_MASK) | (data & CTRL_MAIN_MASK);
          end else begin
            // Force the top field first, then flip the toggle group as a whole
            toggle = data & CTRL_TOGGLE_MASK;
            if ((data & CTRL_FORCE_TRIG) != '0)
              ctrl_word = (ctrl_word & ~CTRL_FIELD_MASK) | CTRL_FIELD_VAL;
            if ((ctrl_word & toggle) != '0) ctrl_word = ctrl_word & ~toggle;
            else ctrl_word = ctrl_word | toggle;
          end
        end
        REG_FIFO0: begin
          if (fifo0_words.size() >= FIFO_DEPTH) rsp.status = ST_FULL_DROP;
          else fifo0_words.push_back(data);
        end
        REG_FIFO1: begin
          if (fifo1_words.size() >= FIFO_DEPTH) rsp.status = ST_FULL_DROP;
          else fifo1_words.push_back(data);
        end
        default: ;
      endcase
    end
    rsp.fifo0_count = 6'(fifo0_words.size());
    rsp.fifo1_count = 6'(fifo1_words.size());
    return rsp;
  endfunction

  // Data mix: random words, all-zero/all-one, and control-sized patterns
  function automatic logic [31:0] pick_word();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) return $urandom;
    if (pick < 75) return ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0;
    return 32'($urandom_range(511));
  endfunction

  // Drive one access and record its expected result once accepted
  task automatic send_access(input logic mode, input logic side, input reg_sel_e sel,
                             input logic [31:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= {sel, side, mode};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_responses.push_back(mailbox_access(mode, side, sel, data));
  endtask

  // Hold off the sender until every outstanding result has drained
  task automatic wait_responses_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_val, act_val);
    end
  endtask

  // Receiver: stall at random, compare each result with the oldest prediction
  always @(posedge clk_i) begin
    mbx_response_t exp_rsp;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_responses.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected result: expected none, actual %h/%h",
                   $time, m_axis_tdata, m_axis_tuser);
      end else begin
        exp_rsp = pending_responses.pop_front();
        report_field("read_data", exp_rsp.read_data, m_axis_tdata[31:0]);
        report_field("fifo0_count", 32'(exp_rsp.fifo0_count), 32'(m_axis_tdata[37:32]));
        report_field("fifo1_count", 32'(exp_rsp.fifo1_count), 32'(m_axis_tdata[43:38]));
        report_field("pad", 32'h0, 32'(m_axis_tdata[47:44]));
        report_field("status", 32'(exp_rsp.status), 32'(m_axis_tuser));
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Side rules, extremes, write-only boot word and fifo0 read
  task automatic test_register_rules();
    send_access(MODE_WRITE, SIDE_MAIN, REG_MSCOM, 32'hFFFF_FFFF);
    send_access(MODE_WRITE, SIDE_SUB,  REG_MSCOM, 32'h0);
    send_access(MODE_READ,  SIDE_SUB,  REG_MSCOM, 32'h0);
    send_access(MODE_WRITE, SIDE_SUB,  REG_SMCOM, 32'hFFFF_FFFF);
    send_access(MODE_WRITE, SIDE_MAIN, REG_SMCOM, 32'h0);
    send_access(MODE_READ,  SIDE_MAIN, REG_SMCOM, 32'hFFFF_FFFF);
    send_access(MODE_WRITE, SIDE_MAIN, REG_MSFLG, 32'hFFFF_FFFF);
    send_access(MODE_WRITE, SIDE_SUB,  REG_MSFLG, 32'h0000_FFFF);
    send_access(MODE_READ,  SIDE_SUB,  REG_MSFLG, 32'h0);
    send_access(MODE_WRITE, SIDE_SUB,  REG_SMFLG, 32'hFFFF_FFFF);
    send_access(MODE_WRITE, SIDE_MAIN, REG_SMFLG, 32'hFFFF_0000);
    send_access(MODE_READ,  SIDE_MAIN, REG_SMFLG, 32'h0);
    send_access(MODE_WRITE, SIDE_MAIN, REG_BD6,   32'hFFFF_FFFF);
    send_access(MODE_WRITE, SIDE_SUB,  REG_BD6,   32'h0);
    send_access(MODE_READ,  SIDE_MAIN, REG_BD6,   32'h0);
    send_access(MODE_READ,  SIDE_SUB,  REG_FIFO0, 32'hFFFF_FFFF);
  endtask

  // Main-side bit, forced field and group toggle of the control word
  task automatic test_ctrl_word();
    send_access(MODE_WRITE, SIDE_MAIN, REG_CTRL, 32'hFFFF_FFFF);
    send_access(MODE_WRITE, SIDE_SUB,  REG_CTRL, 32'h0000_0050);
    send_access(MODE_WRITE, SIDE_SUB,  REG_CTRL, 32'h0000_0020);
    send_access(MODE_WRITE, SIDE_SUB,  REG_CTRL, 32'h0000_00F0);
    send_access(MODE_WRITE, SIDE_MAIN, REG_CTRL, 32'h0);
    send_access(MODE_READ,  SIDE_SUB,  REG_CTRL, 32'h0);
  endtask

  task automatic test_empty_pop();
    send_access(MODE_READ,  SIDE_MAIN, REG_FIFO1, 32'h0);
    send_access(MODE_WRITE, SIDE_SUB,  REG_FIFO1, 32'h0);
    send_access(MODE_READ,  SIDE_SUB,  REG_FIFO1, 32'h0);
  endtask

  // Fill both FIFOs past full, then drain fifo1 past empty
  task automatic test_fifo_bounds();
    while (fifo0_words.size() < FIFO_DEPTH)
      send_access(MODE_WRITE, 1'($urandom_range(1)), REG_FIFO0, $urandom);
    send_access(MODE_WRITE, SIDE_SUB, REG_FIFO0, 32'hFFFF_FFFF);
    while (fifo1_words.size() < FIFO_DEPTH)
      send_access(MODE_WRITE, 1'($urandom_range(1)), REG_FIFO1, $urandom);
    send_access(MODE_WRITE, SIDE_MAIN, REG_FIFO1, 32'hFFFF_FFFF);
    while (fifo1_words.size() != 0)
      send_access(MODE_READ, 1'($urandom_range(1)), REG_FIFO1, $urandom);
    send_access(MODE_READ, SIDE_SUB, REG_FIFO1, 32'h0);
  endtask

  // Mixed traffic with fifo1 pushes and pops roughly balanced
  task automatic test_random_traffic(input int unsigned count);
    int unsigned pick;
    logic        side;
    repeat (count) begin
      pick = $urandom_range(99);
      side = 1'($urandom_range(1));
      if (pick < 22)
        send_access(MODE_READ, side, REG_FIFO1, $urandom);
      else if (pick < 44)
        send_access(MODE_WRITE, side, REG_FIFO1, pick_word());
      else if (pick < 50)
        send_access(MODE_WRITE, side, REG_FIFO0, pick_word());
      else if (pick < 82)
        send_access(MODE_WRITE, side, reg_sel_e'($urandom_range(5)), pick_word());
      else
        send_access(MODE_READ, side, reg_sel_e'($urandom_range(6)), $urandom);
    end
  endtask

  initial begin
    main_cmd   = '0;
    sub_cmd    = '0;
    main_flags = '0;
    sub_flags  = '0;
    ctrl_word  = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct  = 21;
    recv_stall_pct = 72;
    test_register_rules();
    test_ctrl_word();
    test_empty_pop();
    wait_responses_drained();
    test_fifo_bounds();
    test_random_traffic(185);
    wait_responses_drained();

    send_idle_pct  = 72;
    recv_stall_pct = 21;
    test_random_traffic(185);
    wait_responses_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(185);
    wait_responses_drained();

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
